### hw/rtl/olst_pkg.sv
// Shared constants and the control bundle that the list controller drives into the cell row.
package olst_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DEPTH_MAX = 64;
    localparam int POS_W     = $clog2(DEPTH_MAX);
    localparam int VAL_W     = 32;

    localparam logic [2:0] ACT_SORT     = 3'd0;
    localparam logic [2:0] ACT_FRONT    = 3'd1;
    localparam logic [2:0] ACT_BACK     = 3'd2;
    localparam logic [2:0] ACT_FIND     = 3'd3;
    localparam logic [2:0] ACT_DUMP_FWD = 3'd4;
    localparam logic [2:0] ACT_DUMP_REV = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic                     probe_load;
        logic                     probe_dn;
        logic                     probe_up;
        logic                     ins_en;
        logic [POS_W-1:0]         ins_pos;
        logic signed [VAL_W-1:0]  ins_val;
    } olst_ctl_t;

endpackage

### hw/rtl/ordered_list_engine_top.sv
// Ordered list engine top: controller, output register and the cell row.
// Full, empty and trivial finds answer from the start state; front/back inserts go via S_INS.
// Sorted insert and find scan one cell per cycle from the head. Dump forward emits one result
// per cycle unless out_ready stalls it; dump reverse first skips DEPTH - occupancy cells.
// One input at a time; a new transaction is taken once the last result is registered.
// Reset (async, active low) clears the control state and occupancy; entries need no clearing.
module ordered_list_engine_top #(
    parameter int DEPTH = olst_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        action,
    input  logic signed [olst_pkg::VAL_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic [3:0]                        position,
    output logic signed [olst_pkg::VAL_W-1:0] entry_value,
    output logic [4:0]                        entry_count,
    output logic                              last
);
    import olst_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_INS,
        S_DUMP_F,
        S_DUMP_R
    } state_t;

    state_t                  state_reg,  state_next;
    logic [2:0]              act_reg,    act_next;
    logic signed [VAL_W-1:0] val_reg,    val_next;
    logic [IDX_W-1:0]        cnt_reg,    cnt_next;
    logic [IDX_W-1:0]        pos_reg,    pos_next;
    logic [OCC_W-1:0]        occ_reg,    occ_next;

    logic                    out_valid_reg;
    logic [1:0]              status_reg;
    logic [3:0]              position_reg;
    logic signed [VAL_W-1:0] entry_value_reg;
    logic [4:0]              entry_count_reg;
    logic                    last_reg;

    logic                    emit;
    logic [1:0]              emit_status;
    logic [IDX_W-1:0]        emit_pos;
    logic signed [VAL_W-1:0] emit_val;
    logic [OCC_W-1:0]        emit_cnt;
    logic                    emit_last;
    logic [IDX_W+3:0]        emit_pos_w;
    logic [OCC_W+4:0]        emit_cnt_w;

    olst_ctl_t               ctl;
    logic signed [VAL_W-1:0] head_probe;
    logic signed [VAL_W-1:0] tail_probe;

    logic                    out_free;
    logic                    full;
    logic                    at_end;
    logic                    hit;

    assign out_free = !out_valid_reg || out_ready;
    assign full     = (occ_reg == OCC_W'(DEPTH));
    assign at_end   = ((OCC_W'(cnt_reg) + OCC_W'(1)) == occ_reg);
    assign hit      = (act_reg == ACT_FIND) ? (head_probe == val_reg)
                                            : (head_probe > val_reg);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        val_next    = val_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        occ_next    = occ_reg;

        emit        = 1'b0;
        emit_status = ST_OK;
        emit_pos    = '0;
        emit_val    = val_reg;
        emit_cnt    = occ_reg;
        emit_last   = 1'b1;

        ctl            = '0;
        ctl.ins_pos    = POS_W'(pos_reg);
        ctl.ins_val    = val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action;
                    val_next   = value;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                cnt_next = '0;
                case (act_reg)
                    ACT_SORT, ACT_FRONT, ACT_BACK:
                    begin
                        if (full)
                        begin
                            if (out_free)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_FULL;
                                state_next  = S_IDLE;
                            end
                        end
                        else if (act_reg == ACT_FRONT)
                        begin
                            pos_next   = '0;
                            state_next = S_INS;
                        end
                        else if (act_reg == ACT_BACK || occ_reg == '0)
                        begin
                            pos_next   = IDX_W'(occ_reg);
                            state_next = S_INS;
                        end
                        else
                        begin
                            ctl.probe_load = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end

                    ACT_FIND:
                    begin
                        if (occ_reg == '0)
                        begin
                            if (out_free)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_NOT_FOUND;
                                state_next  = S_IDLE;
                            end
                        end
                        else
                        begin
                            ctl.probe_load = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end

                    ACT_DUMP_FWD, ACT_DUMP_REV:
                    begin
                        if (occ_reg == '0)
                        begin
                            if (out_free)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_EMPTY;
                                emit_val    = '0;
                                state_next  = S_IDLE;
                            end
                        end
                        else
                        begin
                            ctl.probe_load = 1'b1;
                            if (act_reg == ACT_DUMP_FWD)
                            begin
                                state_next = S_DUMP_F;
                            end
                            else
                            begin
                                cnt_next   = IDX_W'(DEPTH - 1);
                                state_next = S_DUMP_R;
                            end
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (act_reg == ACT_FIND)
                begin
                    if (hit || at_end)
                    begin
                        if (out_free)
                        begin
                            emit        = 1'b1;
                            emit_status = hit ? ST_OK : ST_NOT_FOUND;
                            emit_pos    = hit ? cnt_reg : '0;
                            state_next  = S_IDLE;
                        end
                    end
                    else
                    begin
                        ctl.probe_dn = 1'b1;
                        cnt_next     = cnt_reg + IDX_W'(1);
                    end
                end
                else if (hit)
                begin
                    pos_next   = cnt_reg;
                    state_next = S_INS;
                end
                else if (at_end)
                begin
                    pos_next   = IDX_W'(occ_reg);
                    state_next = S_INS;
                end
                else
                begin
                    ctl.probe_dn = 1'b1;
                    cnt_next     = cnt_reg + IDX_W'(1);
                end
            end

            S_INS:
            begin
                if (out_free)
                begin
                    ctl.ins_en = 1'b1;
                    occ_next   = occ_reg + OCC_W'(1);
                    emit       = 1'b1;
                    emit_pos   = pos_reg;
                    emit_cnt   = occ_reg + OCC_W'(1);
                    state_next = S_IDLE;
                end
            end

            S_DUMP_F:
            begin
                if (out_free)
                begin
                    emit         = 1'b1;
                    emit_pos     = cnt_reg;
                    emit_val     = head_probe;
                    emit_last    = at_end;
                    ctl.probe_dn = 1'b1;
                    if (at_end)
                        state_next = S_IDLE;
                    else
                        cnt_next = cnt_reg + IDX_W'(1);
                end
            end

            S_DUMP_R:
            begin
                // cells at or above occupancy hold nothing: shift them past the tail
                if (OCC_W'(cnt_reg) >= occ_reg)
                begin
                    ctl.probe_up = 1'b1;
                    cnt_next     = cnt_reg - IDX_W'(1);
                end
                else if (out_free)
                begin
                    emit         = 1'b1;
                    emit_pos     = cnt_reg;
                    emit_val     = tail_probe;
                    emit_last    = (cnt_reg == '0);
                    ctl.probe_up = 1'b1;
                    if (cnt_reg == '0)
                        state_next = S_IDLE;
                    else
                        cnt_next = cnt_reg - IDX_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign emit_pos_w = {4'b0, emit_pos};
    assign emit_cnt_w = {5'b0, emit_cnt};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        val_reg <= val_next;
        cnt_reg <= cnt_next;
        pos_reg <= pos_next;
        if (emit)
        begin
            status_reg      <= emit_status;
            position_reg    <= emit_pos_w[3:0];
            entry_value_reg <= emit_val;
            entry_count_reg <= emit_cnt_w[4:0];
            last_reg        <= emit_last;
        end
    end

    olst_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .clk        (clk),
        .ctl        (ctl),
        .head_probe (head_probe),
        .tail_probe (tail_probe)
    );

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign position    = position_reg;
    assign entry_value = entry_value_reg;
    assign entry_count = entry_count_reg;
    assign last        = last_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    a_occ_only_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_INS) |=> $stable(occ_reg))
        else $error("occupancy changed outside insert");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS && out_free) |=> (occ_reg == $past(occ_reg) + OCC_W'(1)))
        else $error("insert did not grow the list");

    a_pending_results: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (state_reg == S_DUMP_F || state_reg == S_DUMP_R))
        else $error("non-final result with no dump in progress");

endmodule

### hw/rtl/olst_cell.sv
// One list cell: a stored entry plus a probe copy that walks toward either end of the row.
module olst_cell #(
    parameter int IDX = 0
) (
    input  logic                             clk,
    input  olst_pkg::olst_ctl_t              ctl,
    input  logic signed [olst_pkg::VAL_W-1:0] left_entry,
    input  logic signed [olst_pkg::VAL_W-1:0] probe_above,
    input  logic signed [olst_pkg::VAL_W-1:0] probe_below,
    output logic signed [olst_pkg::VAL_W-1:0] entry,
    output logic signed [olst_pkg::VAL_W-1:0] probe
);
    import olst_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic signed [VAL_W-1:0] entry_reg;
    logic signed [VAL_W-1:0] probe_reg;

    // insert: the cell at the slot takes the new value, cells above it move up one
    always_ff @(posedge clk)
    begin
        if (ctl.ins_en)
        begin
            if (ctl.ins_pos == MY_POS)
                entry_reg <= ctl.ins_val;
            else if (MY_POS > ctl.ins_pos)
                entry_reg <= left_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.probe_load)
            probe_reg <= entry_reg;
        else if (ctl.probe_dn)
            probe_reg <= probe_above;
        else if (ctl.probe_up)
            probe_reg <= probe_below;
    end

    assign entry = entry_reg;
    assign probe = probe_reg;

endmodule

### hw/rtl/olst_chain.sv
// Row of list cells; cell 0 is the head, the probe copy is read at either end.
module olst_chain #(
    parameter int DEPTH = olst_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  olst_pkg::olst_ctl_t               ctl,
    output logic signed [olst_pkg::VAL_W-1:0] head_probe,
    output logic signed [olst_pkg::VAL_W-1:0] tail_probe
);
    import olst_pkg::*;

    logic signed [VAL_W-1:0] entry_w [DEPTH];
    logic signed [VAL_W-1:0] probe_w [DEPTH];

    for (genvar j = 0; j < DEPTH; j++)
    begin : g_cell
        logic signed [VAL_W-1:0] left_w;
        logic signed [VAL_W-1:0] above_w;
        logic signed [VAL_W-1:0] below_w;

        if (j == 0)
        begin : g_head
            assign left_w  = '0;
            assign below_w = '0;
        end
        else
        begin : g_mid
            assign left_w  = entry_w[j-1];
            assign below_w = probe_w[j-1];
        end

        if (j == DEPTH - 1)
        begin : g_tail
            assign above_w = '0;
        end
        else
        begin : g_body
            assign above_w = probe_w[j+1];
        end

        olst_cell #(
            .IDX (j)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .left_entry  (left_w),
            .probe_above (above_w),
            .probe_below (below_w),
            .entry       (entry_w[j]),
            .probe       (probe_w[j])
        );
    end

    assign head_probe = probe_w[0];
    assign tail_probe = probe_w[DEPTH-1];

endmodule
